// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros included by the decoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, phase codes and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam logic [7:0] CHAR_PAD = 8'h3d;   // '='

   localparam logic [1:0] PH_DECODE = 2'd0;
   localparam logic [1:0] PH_TERM   = 2'd1;
   localparam logic [1:0] PH_FAIL   = 2'd2;

   typedef struct packed {
      logic [17:0] acc;
      logic [1:0]  pos;
      logic [1:0]  phase;
      logic [1:0]  tpos;
      logic [2:0]  tcount;
   } dec_state_type;

   // Results caused by one transaction; bytes[0] is delivered first.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            bare;
      logic            eom;
      logic            bad;
   } result_group_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   // Both the '+/' and the '-_' alphabets are recognised.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         d = c - 8'h41;
         s.hit = 1'b1;
         s.value = d[5:0];
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         d = c - 8'h61 + 8'd26;
         s.hit = 1'b1;
         s.value = d[5:0];
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
         s.hit = 1'b1;
         s.value = d[5:0];
      end else if (c == 8'h2b || c == 8'h2d) begin
         s.hit = 1'b1;
         s.value = 6'd62;
      end else if (c == 8'h2f || c == 8'h5f) begin
         s.hit = 1'b1;
         s.value = 6'd63;
      end
      return s;
   endfunction

endpackage

// ===== design/base64_decoder_core.sv =====
// ----------------------------------------------------------------------------
// base64_decoder_core
// Streaming base64 decoder, one character in, up to three bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one encoded character per transaction, with
//   req_last_char set on the final character of a message. The rsp channel
//   returns decoded bytes one per transaction; the final transaction of a
//   message has rsp_end_of_message set and rsp_status gives the verdict
//   (1 means the whole message is bad and its bytes must be discarded).
//   A bare status transaction has rsp_byte_valid low.
//   csr_wr_en with csr_wr_data selects url mode (1) or standard padded mode
//   (0); the user must write it only while the block is idle (unchecked).
// Timing:
//   Results of a character appear in the cycle after it is accepted.
//   The result port delivers one byte per cycle unless rsp_stall is high;
//   a character with several results holds off the next until all but its
//   last have left. A new character is taken as the last pending result
//   leaves, so one-result characters stream at one per cycle unless stalled.
// Reset and stalls:
//   Synchronous reset clears the decoder state, drops pending results and
//   returns to standard mode. While rsp_stall is high the pending result
//   holds and req_stall is raised once no result slot would be free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_decoder_core
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_message,
   output logic       rsp_status,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic             url_mode_ff;
   dec_state_type    state_ff;
   dec_state_type    state_in;
   result_group_type group;

   // Result register: pending bytes with the next one to leave in slot 0.
   logic [2:0][7:0]  bytes_ff;
   logic [1:0]       rem_ff;
   logic             bare_ff;
   logic             eom_ff;
   logic             bad_ff;

   logic             req_accept;
   logic             rsp_accept;

   b64d_step u_step (
      .cur       (state_ff),
      .char_code (req_char_code),
      .last_char (req_last_char),
      .url_mode  (url_mode_ff),
      .nxt       (state_in),
      .group     (group)
   );

   // The result register frees up when nothing is pending, or when the
   // only pending result is taken in this cycle.
   assign req_stall  = (rem_ff > 2'd1) || (rem_ff == 2'd1 && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid          = rem_ff != 2'd0;
   assign rsp_accept         = rsp_valid && !rsp_stall;
   assign rsp_data_byte      = bytes_ff[0];
   assign rsp_byte_valid     = !bare_ff;
   assign rsp_end_of_message = eom_ff && rem_ff == 2'd1;
   assign rsp_status         = bad_ff && eom_ff && rem_ff == 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         url_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (req_accept) begin
         rem_ff <= group.count;
      end else if (rsp_accept) begin
         rem_ff <= rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bytes_ff <= group.bytes;
         bare_ff  <= group.bare;
         eom_ff   <= group.eom;
         bad_ff   <= group.bad;
      end else if (rsp_accept) begin
         bytes_ff <= {8'h00, bytes_ff[2], bytes_ff[1]};
      end
   end

   // A character is only taken once every earlier result has gone.
   `ASSERT_CLK(a_accept_when_free, req_accept |-> (rem_ff == 2'd0 || (rem_ff == 2'd1 && rsp_accept)), "character accepted over pending results")
   // A bad verdict is only shown on the closing transaction.
   `ASSERT_CLK(a_status_on_end, (rsp_valid && rsp_status) |-> rsp_end_of_message, "status outside end of message")
   // A bare transaction always closes a message.
   `ASSERT_CLK(a_bare_is_end, (rsp_valid && !rsp_byte_valid) |-> rsp_end_of_message, "bare result not at end of message")
   // The decoder starts afresh after every last character.
   `ASSERT_CLK(a_clear_after_last, (req_accept && req_last_char) |=> (state_ff == '0), "state not cleared after message")
   // A failed message stays silent until its last character.
   `ASSERT_CLK(a_fail_silent, (req_accept && state_ff.phase >= PH_FAIL && !req_last_char) |=> !rsp_valid, "output from a failed message")

endmodule

// ===== design/b64d_step.sv =====
// ----------------------------------------------------------------------------
// b64d_step
// Next-state and result logic for one input character.
// ----------------------------------------------------------------------------
module b64d_step
   import b64d_pkg::*;
(
   input  dec_state_type    cur,
   input  logic [7:0]       char_code,
   input  logic             last_char,
   input  logic             url_mode,
   output dec_state_type    nxt,
   output result_group_type group
);

   sextet_type s;
   logic [1:0] lo;
   logic       bad;

   assign s  = sextet_of(char_code);

   always_comb begin
      nxt = cur;
      group = '0;
      bad = 1'b0;
      lo = 2'd0;
      if (cur.phase == PH_DECODE) begin
         if (s.hit) begin
            if (cur.pos == 2'd3) begin
               group.bytes[0] = cur.acc[17:10];
               group.bytes[1] = cur.acc[9:2];
               group.bytes[2] = {cur.acc[1:0], s.value};
               group.count = 2'd3;
               nxt.acc = '0;
               nxt.pos = 2'd0;
            end else begin
               nxt.acc = {cur.acc[11:0], s.value};
               nxt.pos = cur.pos + 2'd1;
            end
         end else if (cur.pos < 2'd2 || (!url_mode && char_code != CHAR_PAD)) begin
            nxt.phase = PH_FAIL;
         end else begin
            if (cur.pos == 2'd3) begin
               group.bytes[0] = cur.acc[17:10];
               group.bytes[1] = cur.acc[9:2];
               group.count = 2'd2;
            end else begin
               group.bytes[0] = cur.acc[11:4];
               group.count = 2'd1;
            end
            nxt.phase = PH_TERM;
            nxt.tpos = cur.pos;
            nxt.tcount = 3'd0;
         end
      end else if (cur.phase == PH_TERM) begin
         if (cur.tcount != 3'd7) begin
            nxt.tcount = cur.tcount + 3'd1;
         end
      end

      if (last_char) begin
         priority if (nxt.phase == PH_DECODE) begin
            if (nxt.pos == 2'd0) begin
               bad = 1'b0;
            end else if (!url_mode || nxt.pos == 2'd1) begin
               bad = 1'b1;
            end else if (nxt.pos == 2'd3) begin
               // Unpadded tail of three characters.
               group.bytes[0] = nxt.acc[17:10];
               group.bytes[1] = nxt.acc[9:2];
               group.count = 2'd2;
            end else begin
               group.bytes[0] = nxt.acc[11:4];
               group.count = 2'd1;
            end
         end else if (nxt.phase == PH_TERM) begin
            // Characters still owed after the terminator to close its group.
            lo = 2'd3 - nxt.tpos;
            if (!url_mode) begin
               bad = nxt.tcount != {1'b0, lo};
            end else begin
               bad = (nxt.tcount < {1'b0, lo}) ||
                     ({1'b0, nxt.tcount} > ({2'b00, lo} + 4'd3));
            end
         end else begin
            bad = 1'b1;
         end

         if (bad || group.count == 2'd0) begin
            group.bytes = '0;
            group.count = 2'd1;
            group.bare = 1'b1;
         end
         group.eom = 1'b1;
         group.bad = bad;
         nxt = '0;
      end
   end

endmodule

// ===== verif/base64_decoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_core_test
// Self-checking testbench for the streaming base64 decoder. Encoded
// messages, damaged messages and random noise are sent in both decoding
// modes. A scoreboard class decodes every accepted character on its own and
// checks the decoded bytes and the end-of-message verdicts in order.
// ----------------------------------------------------------------------------
module base64_decoder_core_test;
   import b64d_pkg::*;

   localparam int RANDOM_ITEMS   = 400;
   localparam int IDLE_PERCENT   = 11;
   // A character with no result may still be in flight when the expected
   // bytes have all arrived, so the sender waits this many cycles on top.
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
      logic       status;
   } decoded_byte_type;

   // -------------------------------------------------------------------------
   // Scoreboard: its own copy of the decoder state and of the mode register.
   // -------------------------------------------------------------------------
   class b64_scoreboard;
      logic             url_mode;
      logic [17:0]      acc;
      logic [1:0]       pos;
      logic [1:0]       phase;
      logic [1:0]       tpos;
      logic [2:0]       tcount;
      decoded_byte_type expected_bytes[$];
      decoded_byte_type step_bytes[$];
      int               errors;

      function new();
         url_mode = 1'b0;
         errors   = 0;
         clear_message();
      endfunction

      function void clear_message();
         acc    = '0;
         pos    = '0;
         phase  = PH_DECODE;
         tpos   = '0;
         tcount = '0;
      endfunction

      // Bit 6 says whether the character is in either alphabet.
      function logic [6:0] alphabet_value(logic [7:0] c);
         if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
         if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
         if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
         if (c == "+" || c == "-") return {1'b1, 6'd62};
         if (c == "/" || c == "_") return {1'b1, 6'd63};
         return 7'd0;
      endfunction

      function void emit_byte(logic [7:0] b);
         decoded_byte_type r;
         r.data_byte      = b;
         r.byte_valid     = 1'b1;
         r.end_of_message = 1'b0;
         r.status         = 1'b0;
         step_bytes.push_back(r);
      endfunction

      // Remnant bytes of an open group of two or three sextets.
      function void emit_remnant();
         if (pos == 2'd3) begin
            emit_byte(acc[17:10]);
            emit_byte(acc[9:2]);
         end else begin
            emit_byte(acc[11:4]);
         end
      endfunction

      function void decode_char(logic [7:0] c, logic last);
         logic [6:0]       lookup;
         logic [23:0]      w;
         logic             bad;
         int               lo;
         decoded_byte_type r;
         step_bytes = {};
         lookup = alphabet_value(c);
         if (phase == PH_DECODE) begin
            if (lookup[6]) begin
               if (pos == 2'd3) begin
                  w = {acc, lookup[5:0]};
                  emit_byte(w[23:16]);
                  emit_byte(w[15:8]);
                  emit_byte(w[7:0]);
                  acc = '0;
                  pos = '0;
               end else begin
                  acc = {acc[11:0], lookup[5:0]};
                  pos = pos + 2'd1;
               end
            end else if (pos < 2'd2 || (!url_mode && c != CHAR_PAD)) begin
               phase = PH_FAIL;
            end else begin
               emit_remnant();
               phase  = PH_TERM;
               tpos   = pos;
               tcount = '0;
            end
         end else if (phase == PH_TERM) begin
            if (tcount < 3'd7) tcount = tcount + 3'd1;
         end

         if (last) begin
            if (phase == PH_DECODE) begin
               if (pos == 2'd0) begin
                  bad = 1'b0;
               end else if (!url_mode || pos == 2'd1) begin
                  bad = 1'b1;
               end else begin
                  bad = 1'b0;
                  emit_remnant();
               end
            end else if (phase == PH_TERM) begin
               lo = 3 - int'(tpos);
               if (!url_mode) bad = int'(tcount) != lo;
               else bad = int'(tcount) < lo || int'(tcount) > lo + 3;
            end else begin
               bad = 1'b1;
            end
            if (bad) step_bytes = {};
            if (step_bytes.size() == 0) begin
               r = '0;
               step_bytes.push_back(r);
            end
            step_bytes[$].end_of_message = 1'b1;
            step_bytes[$].status         = bad;
            clear_message();
         end
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_byte(decoded_byte_type got);
         decoded_byte_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: data_byte 0x%0h byte_valid %0b eom %0b status %0b",
                   got.data_byte, got.byte_valid, got.end_of_message, got.status);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("end_of_message", want.end_of_message, got.end_of_message);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block itself.
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_code;
   logic       req_last_char;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_message;
   logic       rsp_status;
   logic       csr_wr_en;
   logic       csr_wr_data;

   b64_scoreboard sb = new();

   // Both sides idle at random unless these are cleared.
   logic       req_idle_on;
   logic       rsp_idle_on;
   int         items_sent;
   int         quiet_cycles;
   logic [7:0] msg_chars[$];

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   base64_decoder_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_last_char      (req_last_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // -------------------------------------------------------------------------
   // Result side. The stall is redrawn at every falling edge, so stalls can land
   // on any cycle of a multi-byte group. Results are taken at the rising
   // edge, where the watchdog also counts cycles in which no transaction
   // happened on either channel.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= rsp_idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      decoded_byte_type got;
      got.data_byte      = rsp_data_byte;
      got.byte_valid     = rsp_byte_valid;
      got.end_of_message = rsp_end_of_message;
      got.status         = rsp_status;
      if (!reset && rsp_valid && !rsp_stall) sb.check_byte(got);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Character side.
   // -------------------------------------------------------------------------

   // Drives one character at a falling edge, after an optional random gap,
   // and holds it until the block takes it. The scoreboard sees the
   // character at the edge of the transaction.
   task automatic send_char(input logic [7:0] c, input logic last);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      sb.decode_char(c, last);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic ends_message);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], ends_message && i == s.len() - 1);
      end
   endtask

   task automatic send_message();
      foreach (msg_chars[i]) send_char(msg_chars[i], i == msg_chars.size() - 1);
   endtask

   // Stops the sender and waits until every expected byte has come back,
   // then lets the block settle so that it is truly idle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The mode register is only written while the decoder is idle.
   task automatic set_mode(input logic url);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= url;
      @(posedge clock);
      sb.url_mode = url;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Character for a sextet, with a random pick between the two alphabets.
   function automatic logic [7:0] sextet_char(logic [5:0] v);
      if (v < 6'd26) return 8'(v) + "A";
      if (v < 6'd52) return 8'(v - 6'd26) + "a";
      if (v < 6'd62) return 8'(v - 6'd52) + "0";
      if (v == 6'd62) return $urandom_range(1) ? "+" : "-";
      return $urandom_range(1) ? "/" : "_";
   endfunction

   function automatic logic [7:0] non_alphabet_char();
      logic [7:0] c;
      logic [6:0] lookup;
      do begin
         c = 8'($urandom_range(255));
         lookup = sb.alphabet_value(c);
      end while (lookup[6]);
      return c;
   endfunction

   // Encodes nbytes random bytes for the current mode. The bits of a partial
   // group below the last data byte are random, as the decoder ignores them.
   // In url mode a tail may be unpadded, padded with any non-alphabet
   // character, or followed by a few further characters.
   task automatic build_encoded(input int nbytes);
      logic [23:0] w;
      int          chunk;
      msg_chars = {};
      for (int i = 0; i < nbytes; i += 3) begin
         chunk = (nbytes - i < 3) ? nbytes - i : 3;
         w = 24'($urandom);
         msg_chars.push_back(sextet_char(w[23:18]));
         msg_chars.push_back(sextet_char(w[17:12]));
         if (chunk >= 2) msg_chars.push_back(sextet_char(w[11:6]));
         if (chunk == 3) msg_chars.push_back(sextet_char(w[5:0]));
         if (chunk < 3 && (!sb.url_mode || $urandom_range(2) != 0)) begin
            if (!sb.url_mode || $urandom_range(1)) msg_chars.push_back(CHAR_PAD);
            else msg_chars.push_back(non_alphabet_char());
            if (chunk == 1) msg_chars.push_back(CHAR_PAD);
            if (sb.url_mode && $urandom_range(3) == 0) begin
               repeat ($urandom_range(1, 3)) msg_chars.push_back(8'($urandom_range(255)));
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int kind;
      int idx;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      items_sent    = 0;
      quiet_cycles  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, standard mode first. A full group over both
      // alphabets, a padded single byte, a pad in the first position, a
      // terminator that is not a pad and an unfinished group at the end.
      set_mode(1'b0);
      send_text("Tw-_", 1'b1);
      send_text("TQ==", 1'b1);
      send_text("=", 1'b1);
      send_text("TW", 1'b0);
      send_char(8'hff, 1'b0);
      send_char(CHAR_PAD, 1'b1);
      send_text("TWF", 1'b1);

      // Url mode: an unpadded tail of three, a lone leftover character, and
      // a non-alphabet terminator followed by a trailing character.
      set_mode(1'b1);
      send_text("TWE", 1'b1);
      send_text("T", 1'b1);
      send_text("TQ", 1'b0);
      send_char(8'hff, 1'b0);
      send_text("9", 1'b1);

      // The mode changes in the middle of a message, which the decoder must
      // honour at the step where it decides.
      set_mode(1'b0);
      send_text("TW", 1'b0);
      set_mode(1'b1);
      send_text("E", 1'b1);

      // Random part: mostly well-formed messages with random content, the
      // rest damaged messages and plain noise. For a stretch in the middle
      // neither side idles at all.
      idx = items_sent;
      while (items_sent < idx + RANDOM_ITEMS) begin
         req_idle_on = !(items_sent >= idx + 150 && items_sent < idx + 250);
         rsp_idle_on = req_idle_on;
         if ($urandom_range(7) == 0) set_mode(1'($urandom_range(1)));
         kind = $urandom_range(99);
         if (kind < 90) begin
            build_encoded(($urandom_range(9) == 0) ? $urandom_range(10, 24)
                                                   : $urandom_range(1, 9));
            if (kind >= 75) begin
               msg_chars[$urandom_range(msg_chars.size() - 1)] = 8'($urandom_range(255));
               if ($urandom_range(1) && msg_chars.size() > 1) void'(msg_chars.pop_back());
            end
         end else begin
            msg_chars = {};
            repeat ($urandom_range(1, 8)) msg_chars.push_back(8'($urandom_range(255)));
         end
         send_message();
      end

      // Everything sent: wait for the last bytes and let the block settle.
      wait_drained();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
